// File: sv/ecss_pkg.sv
// ----------------------------------------------------------------------------
// ecss_pkg
// Shared types, constants and helpers of the edge and centre snap search
// ----------------------------------------------------------------------------
package ecss_pkg;

   localparam int ECSS_COORD_BITS = 24;
   localparam int ECSS_FRAC_BITS  = 4;
   localparam int ECSS_SIZE_BITS  = ECSS_COORD_BITS - 1;
   localparam int ECSS_LINE_BITS  = ECSS_COORD_BITS + 1;
   localparam int ECSS_THR_BITS   = 16;
   localparam int ECSS_DIFF_BITS  = (ECSS_COORD_BITS + 2 > ECSS_THR_BITS + 2) ?
                                    ECSS_COORD_BITS + 2 : ECSS_THR_BITS + 2;

   localparam logic [ECSS_THR_BITS-1:0] ECSS_THR_RESET = ECSS_THR_BITS'(128);

   localparam int ECSS_ADDR_BITS = 3;
   localparam int ECSS_DATA_BITS = 32;
   localparam int ECSS_REG_LSB   = 2;
   localparam int ECSS_IDX_BITS  = ECSS_ADDR_BITS - ECSS_REG_LSB;

   localparam logic [ECSS_IDX_BITS-1:0] ECSS_REG_THRESHOLD = ECSS_IDX_BITS'(0);

   localparam logic ECSS_CMD_START = 1'b0;

   typedef struct packed {
      logic                              command;
      logic signed [ECSS_COORD_BITS-1:0] x;
      logic signed [ECSS_COORD_BITS-1:0] y;
      logic [ECSS_SIZE_BITS-1:0]         width;
      logic [ECSS_SIZE_BITS-1:0]         height;
      logic                              last;
   } ecss_req_type;

   typedef struct packed {
      logic signed [ECSS_COORD_BITS-1:0] out_x;
      logic signed [ECSS_COORD_BITS-1:0] out_y;
      logic                              hit_x;
      logic                              hit_y;
      logic signed [ECSS_COORD_BITS-1:0] guide_x;
      logic signed [ECSS_COORD_BITS-1:0] guide_y;
   } ecss_rsp_type;

   // best offset of one target on one axis and the target line it lands on
   typedef struct packed {
      logic signed [ECSS_DIFF_BITS-1:0] diff;
      logic signed [ECSS_LINE_BITS-1:0] line;
   } ecss_cand_type;

   // per-axis outcome after an item
   typedef struct packed {
      logic [ECSS_COORD_BITS-1:0] snapped;
      logic                       hit;
      logic [ECSS_COORD_BITS-1:0] guide;
   } ecss_axis_res_type;

   function automatic logic [ECSS_DIFF_BITS-1:0] ecss_mag(
      input logic signed [ECSS_DIFF_BITS-1:0] v);
      ecss_mag = v[ECSS_DIFF_BITS-1] ? -v : v;
   endfunction

endpackage

// File: sv/ecss_axis_min.sv
// ----------------------------------------------------------------------------
// ecss_axis_min
// Nine box-to-target line offsets on one axis, reduced to the first smallest
// ----------------------------------------------------------------------------
module ecss_axis_min import ecss_pkg::*; (
   input  logic signed [ECSS_COORD_BITS-1:0] prop,
   input  logic [ECSS_SIZE_BITS-1:0]         prop_size,
   input  logic signed [ECSS_COORD_BITS-1:0] tgt_pos,
   input  logic [ECSS_SIZE_BITS-1:0]         tgt_size,
   output ecss_cand_type                     cand
);

   localparam int LW = ECSS_LINE_BITS;
   localparam int DW = ECSS_DIFF_BITS;

   logic signed [LW-1:0] src  [3];
   logic signed [LW-1:0] tgt  [3];
   ecss_cand_type        lvl0 [9];
   ecss_cand_type        lvl1 [4];
   ecss_cand_type        lvl2 [2];
   ecss_cand_type        lvl3;

   // right side wins only when strictly smaller, so the earlier one keeps ties
   function automatic ecss_cand_type pick(input ecss_cand_type a, input ecss_cand_type b);
      pick = (ecss_mag(b.diff) < ecss_mag(a.diff)) ? b : a;
   endfunction

   always_comb begin
      src[0] = {prop[ECSS_COORD_BITS-1], prop};
      src[1] = {prop[ECSS_COORD_BITS-1], prop} + $signed({3'b000, prop_size[ECSS_SIZE_BITS-1:1]});
      src[2] = {prop[ECSS_COORD_BITS-1], prop} + $signed({2'b00, prop_size});
      tgt[0] = {tgt_pos[ECSS_COORD_BITS-1], tgt_pos};
      tgt[1] = {tgt_pos[ECSS_COORD_BITS-1], tgt_pos}
               + $signed({3'b000, tgt_size[ECSS_SIZE_BITS-1:1]});
      tgt[2] = {tgt_pos[ECSS_COORD_BITS-1], tgt_pos} + $signed({2'b00, tgt_size});
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            lvl0[i*3+j].diff = {{(DW-LW){tgt[j][LW-1]}}, tgt[j]}
                               - {{(DW-LW){src[i][LW-1]}}, src[i]};
            lvl0[i*3+j].line = tgt[j];
         end
      end
      for (int k = 0; k < 4; k++) begin
         lvl1[k] = pick(lvl0[2*k], lvl0[2*k+1]);
      end
      lvl2[0] = pick(lvl1[0], lvl1[1]);
      lvl2[1] = pick(lvl1[2], lvl1[3]);
      lvl3    = pick(lvl2[0], lvl2[1]);
      cand    = pick(lvl3, lvl0[8]);
   end

endmodule

// File: sv/ecss_axis_track.sv
// ----------------------------------------------------------------------------
// ecss_axis_track
// Running best offset and guide line of one axis, and the snapped outcome
// ----------------------------------------------------------------------------
module ecss_axis_track import ecss_pkg::*; #(
   parameter int FRAC_BITS = ECSS_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic                              start,
   input  logic [ECSS_THR_BITS-1:0]          thr,
   input  ecss_cand_type                     cand,
   input  logic signed [ECSS_COORD_BITS-1:0] prop,
   output ecss_axis_res_type                 res
);

   localparam int DW = ECSS_DIFF_BITS;
   localparam int LW = ECSS_LINE_BITS;
   localparam logic [DW-1:0] ONE_UNIT = DW'(1) << FRAC_BITS;

   logic signed [DW-1:0] best_ff, best_in;
   logic signed [LW-1:0] line_ff, line_in;
   logic [DW-1:0]        thr_ext;

   always_comb begin
      thr_ext = {{(DW-ECSS_THR_BITS){1'b0}}, thr};
      if (start) begin
         best_in = $signed(thr_ext + ONE_UNIT);
         line_in = '0;
      end else if (ecss_mag(cand.diff) < ecss_mag(best_ff)) begin
         best_in = cand.diff;
         line_in = cand.line;
      end else begin
         best_in = best_ff;
         line_in = line_ff;
      end
      res.hit     = ecss_mag(best_in) <= thr_ext;
      res.snapped = res.hit ? prop + best_in[ECSS_COORD_BITS-1:0] : prop;
      res.guide   = res.hit ? line_in[ECSS_COORD_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= $signed({{(DW-ECSS_THR_BITS){1'b0}}, ECSS_THR_RESET} + ONE_UNIT);
         line_ff <= '0;
      end else if (step) begin
         best_ff <= best_in;
         line_ff <= line_in;
      end
   end

endmodule

// File: sv/edge_center_snap_search.sv
// ----------------------------------------------------------------------------
// edge_center_snap_search
// Snaps a dragged box to the nearest edge or centre line of streamed targets
// ----------------------------------------------------------------------------
// A start transfer (command 0) on req_ loads the proposed top-left corner and
// size of the dragged box; target transfers (command 1) follow, one rectangle
// each. The transfer with last set produces one result on rsp_: the snapped
// position, per-axis hit flags and guide-line coordinates.
// A transfer passes through an input register, a stage holding each target's
// best line offset per axis, and the result register. One transfer is
// accepted every cycle while req_ready is high. The running best is compared
// and updated as each transfer leaves the compare stage.
// While a result waits on rsp_ready, targets keep flowing until a further
// last transfer reaches the compare stage; then req_ready drops once the input register is also full.
// The snap threshold is written through the csr_ port at byte address 0.
// Reset restores a threshold of 8.0, a zero proposal at the origin, and an
// empty search; no clearing pass is needed.
// ----------------------------------------------------------------------------
module edge_center_snap_search import ecss_pkg::*; #(
   parameter int FRAC_BITS = ECSS_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ecss_req_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ecss_rsp_type              rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [ECSS_ADDR_BITS-1:0] csr_paddr,
   input  logic [ECSS_DATA_BITS-1:0] csr_pwdata,
   output logic [ECSS_DATA_BITS-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic                              s1_valid_ff, s1_valid_in;
   ecss_req_type                      s1_req_ff;
   logic signed [ECSS_COORD_BITS-1:0] prop_left_ff, prop_top_ff;
   logic [ECSS_SIZE_BITS-1:0]         box_width_ff, box_height_ff;
   logic                              s2_valid_ff, s2_valid_in;
   logic                              s2_start_ff, s2_last_ff;
   ecss_cand_type                     s2_cand_x_ff, s2_cand_y_ff;
   logic signed [ECSS_COORD_BITS-1:0] s2_prop_x_ff, s2_prop_y_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   ecss_rsp_type                      rsp_data_ff, rsp_data_in;
   logic [ECSS_THR_BITS-1:0]          thr_ff;

   logic                              out_free, s2_adv, s2_fire, s1_fire, req_fire;
   logic                              s1_start, csr_write;
   logic [ECSS_IDX_BITS-1:0]          csr_idx;
   ecss_cand_type                     cand_x, cand_y;
   ecss_axis_res_type                 res_x, res_y;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || !s2_last_ff || out_free;
   assign s2_fire   = s2_valid_ff && s2_adv;
   assign s1_fire   = s1_valid_ff && s2_adv;
   assign req_ready = !s1_valid_ff || s2_adv;
   assign req_fire  = req_valid && req_ready;
   assign s1_start  = s1_req_ff.command == ECSS_CMD_START;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = (s2_fire && s2_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   ecss_axis_min u_min_x (
      .prop      (prop_left_ff),
      .prop_size (box_width_ff),
      .tgt_pos   (s1_req_ff.x),
      .tgt_size  (s1_req_ff.width),
      .cand      (cand_x)
   );

   ecss_axis_min u_min_y (
      .prop      (prop_top_ff),
      .prop_size (box_height_ff),
      .tgt_pos   (s1_req_ff.y),
      .tgt_size  (s1_req_ff.height),
      .cand      (cand_y)
   );

   ecss_axis_track #(.FRAC_BITS(FRAC_BITS)) u_track_x (
      .clock (clock),
      .reset (reset),
      .step  (s2_fire),
      .start (s2_start_ff),
      .thr   (thr_ff),
      .cand  (s2_cand_x_ff),
      .prop  (s2_prop_x_ff),
      .res   (res_x)
   );

   ecss_axis_track #(.FRAC_BITS(FRAC_BITS)) u_track_y (
      .clock (clock),
      .reset (reset),
      .step  (s2_fire),
      .start (s2_start_ff),
      .thr   (thr_ff),
      .cand  (s2_cand_y_ff),
      .prop  (s2_prop_y_ff),
      .res   (res_y)
   );

   always_comb begin
      rsp_data_in.out_x   = res_x.snapped;
      rsp_data_in.out_y   = res_y.snapped;
      rsp_data_in.hit_x   = res_x.hit;
      rsp_data_in.hit_y   = res_y.hit;
      rsp_data_in.guide_x = res_x.guide;
      rsp_data_in.guide_y = res_y.guide;
   end

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[ECSS_ADDR_BITS-1:ECSS_REG_LSB];
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         ECSS_REG_THRESHOLD: begin
            csr_prdata = {{(ECSS_DATA_BITS-ECSS_THR_BITS){1'b0}}, thr_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // control and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= ECSS_THR_RESET;
         prop_left_ff  <= '0;
         prop_top_ff   <= '0;
         box_width_ff  <= '0;
         box_height_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && csr_idx == ECSS_REG_THRESHOLD) begin
            thr_ff <= csr_pwdata[ECSS_THR_BITS-1:0];
         end
         if (s1_fire && s1_start) begin
            prop_left_ff  <= s1_req_ff.x;
            prop_top_ff   <= s1_req_ff.y;
            box_width_ff  <= s1_req_ff.width;
            box_height_ff <= s1_req_ff.height;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         s2_start_ff  <= s1_start;
         s2_last_ff   <= s1_req_ff.last;
         s2_cand_x_ff <= cand_x;
         s2_cand_y_ff <= cand_y;
         s2_prop_x_ff <= s1_start ? s1_req_ff.x : prop_left_ff;
         s2_prop_y_ff <= s1_start ? s1_req_ff.y : prop_top_ff;
      end
      if (s2_fire && s2_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result raised without a last transfer in the compare stage");

   a_last_held: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff && rsp_valid && !rsp_ready |=> s2_valid_ff && s2_last_ff)
      else $error("last transfer left the compare stage while the result was blocked");

   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && s2_valid_ff && s2_last_ff && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_guide_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit_x |-> rsp_data.guide_x == '0)
      else $error("guide_x set without a horizontal hit");

endmodule
